// ===== sv/fdq_pkg.sv =====
// Shared constants, types and codes of the frame delta quantizer.
package fdq_pkg;

  // Fixed-point format and gate windows
  localparam int FRAC_BITS         = 16;
  localparam int CUTSCENE_DECAY_MS = 100;
  localparam int WORLD_DECAY_MS    = 300;

  // Field widths
  localparam int CMD_W      = 2;
  localparam int TIME_W     = 32;
  localparam int TICK_W     = 32;
  localparam int DELTA_W    = 9;
  localparam int EXACT_W    = 25;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int MIN_RATE_W = 5;
  localparam int TGT_RATE_W = 8;

  // Datapath widths
  localparam int SCALE_W = 7;                   // holds the constant 100
  localparam int PROD_W  = TICK_W + SCALE_W;    // ticks * 100
  localparam int QW      = FRAC_BITS + 9;       // clamped quotient, below 512.0
  localparam int DW      = PROD_W + FRAC_BITS;  // dividend
  localparam int HI_W    = DW - QW;             // dividend bits above the quotient
  localparam int RW      = FRAC_BITS + 11;      // signed carried remainder and base
  localparam int CNT_W   = $clog2(QW);

  // Constants in fixed point
  localparam logic [SCALE_W-1:0]       TICK_SCALE = SCALE_W'(100);
  localparam logic [DW-1:0]            FULL_SCALE = DW'(3000) << FRAC_BITS;
  localparam logic [QW-1:0]            SNAP_WIN   = QW'(3) << FRAC_BITS;
  localparam logic signed [RW-1:0]     ONE_FX     = RW'(1) << FRAC_BITS;
  localparam logic signed [RW-1:0]     FLOOR_MASK = ~((RW'(1) << FRAC_BITS) - RW'(1));
  // Lowest remainder: -512.0
  localparam logic signed [RW-1:0]     REM_MIN    = {2'b11, {(RW-2){1'b0}}};

  // Rate limits
  localparam logic [MIN_RATE_W-1:0] MIN_RATE_LO = MIN_RATE_W'(10);
  localparam logic [MIN_RATE_W-1:0] MIN_RATE_HI = MIN_RATE_W'(30);
  localparam logic [TGT_RATE_W-1:0] TGT_RATE_LO = TGT_RATE_W'(10);
  localparam logic [TGT_RATE_W-1:0] TGT_RATE_HI = TGT_RATE_W'(240);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UNLOCK    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CUT_CLAMP = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DYN_PACE  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SNAP      = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_TGT_RATE  = CFG_IDX_W'(5);

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_FRAME    = 2'd0,
    CMD_CUTSCENE = 2'd1,
    CMD_WORLD    = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_CEIL,
    ST_DIV_TGT,
    ST_DIV_EXACT,
    ST_SNAP,
    ST_FLOOR,
    ST_EMIT
  } state_e;

  // Configuration as seen by the datapath, rates already saturated
  typedef struct packed {
    logic                  unlock;
    logic                  cut_clamp;
    logic                  dyn_pace;
    logic                  snap;
    logic [MIN_RATE_W-1:0] min_rate;
    logic [TGT_RATE_W-1:0] tgt_rate;
  } cfg_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [DW-1:0]     dividend;
    logic [TICK_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [QW-1:0] quot;
  } div_rsp_t;

endpackage

// ===== sv/fdq_if.sv =====
// Valid/ready channel interfaces for events in and frame results out.
interface fdq_in_if import fdq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [TIME_W-1:0] now_ms;
  logic [TICK_W-1:0] elapsed_ticks;
  logic [TICK_W-1:0] ticks_per_frame;
  logic              divisor_remapped;

  modport source (
    output valid, cmd, now_ms, elapsed_ticks, ticks_per_frame, divisor_remapped,
    input  ready
  );
  modport sink (
    input  valid, cmd, now_ms, elapsed_ticks, ticks_per_frame, divisor_remapped,
    output ready
  );
endinterface

interface fdq_out_if import fdq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               remap_active;
  logic [DELTA_W-1:0] frame_delta;
  logic               was_snapped;
  logic [EXACT_W-1:0] exact_delta;

  modport source (
    output valid, remap_active, frame_delta, was_snapped, exact_delta,
    input  ready
  );
  modport sink (
    input  valid, remap_active, frame_delta, was_snapped, exact_delta,
    output ready
  );
endinterface

// ===== sv/frame_delta_quantizer_top.sv =====
// Frame delta quantizer top level: sequencer, gate, snap and floor datapath.
//
// Cutscene ticks, world-draw marks and the unused command are accepted
// back to back. A frame measurement occupies the block until its result is
// written to the output register. When the gate is open, the single
// restoring divider, one quotient bit per cycle, works out in turn the delta
// ceiling, the snap target and the exact delta; an exact quotient that
// overflows saturates at once. Events are taken again as soon as the result
// sits in the output register, whether or not it has been taken yet.
// Configuration must only be written while no frame is in flight.
module frame_delta_quantizer_top import fdq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  fdq_in_if.sink                in_ch,
  fdq_out_if.source             out_ch
);

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;
  state_e   state_q, state_d;

  // Timestamp state
  logic [TIME_W-1:0] last_cut_q, last_cut_d;
  logic              cut_seen_q, cut_seen_d;
  logic [TIME_W-1:0] last_world_q, last_world_d;
  logic              world_seen_q, world_seen_d;
  logic signed [RW-1:0] rem_q, rem_d;

  // Latched frame transaction and working values
  logic [TIME_W-1:0]  now_q, now_d;
  logic [TICK_W-1:0]  ticks_q, ticks_d;
  logic [TICK_W-1:0]  tpf_q, tpf_d;
  logic               div_ok_q, div_ok_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [QW-1:0]      ceil_q, ceil_d;
  logic [QW-1:0]      tgt_q, tgt_d;
  logic [QW-1:0]      exact_q, exact_d;
  logic signed [RW-1:0] base_q, base_d;
  logic               snapped_q, snapped_d;
  logic               res_active_q, res_active_d;
  logic [DELTA_W-1:0] res_delta_q, res_delta_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic               out_active_q, out_active_d;
  logic [DELTA_W-1:0] out_delta_q, out_delta_d;
  logic               out_snap_q, out_snap_d;
  logic [EXACT_W-1:0] out_exact_q, out_exact_d;

  logic              in_fire;
  logic              out_load;
  logic [TIME_W-1:0] cut_dt, world_dt;
  logic              cine, world, gate_ok, go;
  logic [QW-1:0]     diff;
  logic signed [RW-1:0] ceil_s, fl, dfx, new_rem;

  fdq_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  fdq_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || out_ch.ready);

  // Remap gate on the latched frame
  assign cut_dt   = now_q - last_cut_q;
  assign world_dt = now_q - last_world_q;
  assign cine     = cfg.cut_clamp && cut_seen_q && (cut_dt <= TIME_W'(CUTSCENE_DECAY_MS));
  assign world    = world_seen_q && (world_dt <= TIME_W'(WORLD_DECAY_MS));
  assign gate_ok  = cfg.unlock && !cine && (!cfg.dyn_pace || world);
  assign go       = gate_ok && div_ok_q && (tpf_q != '0);

  // Snap distance and floor path
  assign diff    = (exact_q >= tgt_q) ? (exact_q - tgt_q) : (tgt_q - exact_q);
  assign ceil_s  = $signed({2'b00, ceil_q});
  assign fl      = base_q & FLOOR_MASK;
  assign dfx     = (base_q < ONE_FX) ? ONE_FX : ((fl > ceil_s) ? ceil_s : fl);
  assign new_rem = base_q - dfx;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_fire && (cmd_e'(in_ch.cmd) == CMD_FRAME)) state_d = ST_CHECK;
      ST_CHECK:     state_d = go ? ST_DIV_CEIL : ST_EMIT;
      ST_DIV_CEIL:  if (div_rsp.done) state_d = ST_DIV_TGT;
      ST_DIV_TGT:   if (div_rsp.done) state_d = ST_DIV_EXACT;
      ST_DIV_EXACT: if (div_rsp.done) state_d = ST_SNAP;
      ST_SNAP:      state_d = ST_FLOOR;
      ST_FLOOR:     state_d = ST_EMIT;
      ST_EMIT:      if (out_load) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: input ready and divider requests
  always_comb begin
    in_ch.ready      = (state_q == ST_IDLE);
    div_req.start    = 1'b0;
    div_req.dividend = FULL_SCALE;
    div_req.divisor  = TICK_W'(cfg.min_rate);
    unique case (state_q)
      ST_CHECK: begin
        div_req.start = go;
      end
      ST_DIV_CEIL: begin
        div_req.start   = div_rsp.done;
        div_req.divisor = TICK_W'(cfg.tgt_rate);
      end
      ST_DIV_TGT: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = {prod_q, {FRAC_BITS{1'b0}}};
        div_req.divisor  = tpf_q;
      end
      default: ;
    endcase
  end

  // Datapath
  always_comb begin
    last_cut_d   = last_cut_q;
    cut_seen_d   = cut_seen_q;
    last_world_d = last_world_q;
    world_seen_d = world_seen_q;
    rem_d        = rem_q;
    now_d        = now_q;
    ticks_d      = ticks_q;
    tpf_d        = tpf_q;
    div_ok_d     = div_ok_q;
    prod_d       = prod_q;
    ceil_d       = ceil_q;
    tgt_d        = tgt_q;
    exact_d      = exact_q;
    base_d       = base_q;
    snapped_d    = snapped_q;
    res_active_d = res_active_q;
    res_delta_d  = res_delta_q;
    unique case (state_q)
      ST_IDLE: begin
        // Stamp events, latch a frame
        if (in_fire) begin
          unique case (cmd_e'(in_ch.cmd))
            CMD_CUTSCENE: begin
              last_cut_d = in_ch.now_ms;
              cut_seen_d = 1'b1;
            end
            CMD_WORLD: begin
              last_world_d = in_ch.now_ms;
              world_seen_d = 1'b1;
            end
            CMD_FRAME: begin
              now_d    = in_ch.now_ms;
              ticks_d  = in_ch.elapsed_ticks;
              tpf_d    = in_ch.ticks_per_frame;
              div_ok_d = in_ch.divisor_remapped;
            end
            CMD_NONE: ;
          endcase
        end
      end
      ST_CHECK: begin
        prod_d = PROD_W'(ticks_q) * PROD_W'(TICK_SCALE);
        // Closed gate: drop the carry, report not remapped
        if (!go) begin
          rem_d        = '0;
          res_active_d = 1'b0;
          res_delta_d  = '0;
          snapped_d    = 1'b0;
          exact_d      = '0;
        end
      end
      ST_DIV_CEIL: begin
        if (div_rsp.done) ceil_d = div_rsp.quot;
      end
      ST_DIV_TGT: begin
        if (div_rsp.done) tgt_d = div_rsp.quot;
      end
      ST_DIV_EXACT: begin
        // Clamp the exact delta to the ceiling
        if (div_rsp.done) exact_d = (div_rsp.quot > ceil_q) ? ceil_q : div_rsp.quot;
      end
      ST_SNAP: begin
        snapped_d = cfg.snap && (tgt_q <= ceil_q) && (diff < SNAP_WIN);
        base_d    = rem_q + $signed({2'b00, exact_q});
      end
      ST_FLOOR: begin
        res_active_d = 1'b1;
        if (snapped_q) begin
          // Round the target half up
          rem_d       = '0;
          res_delta_d = tgt_q[FRAC_BITS +: DELTA_W] + DELTA_W'(tgt_q[FRAC_BITS-1]);
        end else begin
          // Floor with the fraction carried, saturate the carry low
          rem_d       = (new_rem < REM_MIN) ? REM_MIN : new_rem;
          res_delta_d = dfx[FRAC_BITS +: DELTA_W];
        end
      end
      ST_EMIT: ;
      default: ;
    endcase
  end

  // Output register: hold until taken
  always_comb begin
    out_valid_d  = out_valid_q && !out_ch.ready;
    out_active_d = out_active_q;
    out_delta_d  = out_delta_q;
    out_snap_d   = out_snap_q;
    out_exact_d  = out_exact_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_active_d = res_active_q;
      out_delta_d  = res_delta_q;
      out_snap_d   = snapped_q;
      out_exact_d  = EXACT_W'(exact_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      last_cut_q   <= '0;
      cut_seen_q   <= 1'b0;
      last_world_q <= '0;
      world_seen_q <= 1'b0;
      rem_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      last_cut_q   <= last_cut_d;
      cut_seen_q   <= cut_seen_d;
      last_world_q <= last_world_d;
      world_seen_q <= world_seen_d;
      rem_q        <= rem_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q        <= now_d;
    ticks_q      <= ticks_d;
    tpf_q        <= tpf_d;
    div_ok_q     <= div_ok_d;
    prod_q       <= prod_d;
    ceil_q       <= ceil_d;
    tgt_q        <= tgt_d;
    exact_q      <= exact_d;
    base_q       <= base_d;
    snapped_q    <= snapped_d;
    res_active_q <= res_active_d;
    res_delta_q  <= res_delta_d;
    out_active_q <= out_active_d;
    out_delta_q  <= out_delta_d;
    out_snap_q   <= out_snap_d;
    out_exact_q  <= out_exact_d;
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.remap_active = out_active_q;
  assign out_ch.frame_delta  = out_delta_q;
  assign out_ch.was_snapped  = out_snap_q;
  assign out_ch.exact_delta  = out_exact_q;

`ifndef SYNTHESIS
  a_div_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_closed_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK && !go) |=> (rem_q == '0 && state_q == ST_EMIT))
    else $error("closed gate did not clear the carried remainder");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q >= REM_MIN) && (rem_q < ONE_FX))
    else $error("carried remainder out of range");

  a_pass_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_active_q) |->
      (out_delta_q == '0 && !out_snap_q && out_exact_q == '0))
    else $error("not-remapped result carries nonzero fields");
`endif

endmodule

// ===== sv/fdq_cfg.sv =====
// Configuration registers with rate saturation.
module fdq_cfg import fdq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  logic                  unlock_q, unlock_d;
  logic                  cut_clamp_q, cut_clamp_d;
  logic                  dyn_pace_q, dyn_pace_d;
  logic                  snap_q, snap_d;
  logic [MIN_RATE_W-1:0] min_rate_q, min_rate_d;
  logic [TGT_RATE_W-1:0] tgt_rate_q, tgt_rate_d;

  // Decode the write
  always_comb begin
    unlock_d    = unlock_q;
    cut_clamp_d = cut_clamp_q;
    dyn_pace_d  = dyn_pace_q;
    snap_d      = snap_q;
    min_rate_d  = min_rate_q;
    tgt_rate_d  = tgt_rate_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_UNLOCK:    unlock_d    = cfg_data_i[0];
        REG_CUT_CLAMP: cut_clamp_d = cfg_data_i[0];
        REG_DYN_PACE:  dyn_pace_d  = cfg_data_i[0];
        REG_SNAP:      snap_d      = cfg_data_i[0];
        REG_MIN_RATE:  min_rate_d  = cfg_data_i[MIN_RATE_W-1:0];
        REG_TGT_RATE:  tgt_rate_d  = cfg_data_i[TGT_RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unlock_q    <= 1'b1;
      cut_clamp_q <= 1'b1;
      dyn_pace_q  <= 1'b1;
      snap_q      <= 1'b1;
      min_rate_q  <= MIN_RATE_W'(20);
      tgt_rate_q  <= TGT_RATE_W'(60);
    end else begin
      unlock_q    <= unlock_d;
      cut_clamp_q <= cut_clamp_d;
      dyn_pace_q  <= dyn_pace_d;
      snap_q      <= snap_d;
      min_rate_q  <= min_rate_d;
      tgt_rate_q  <= tgt_rate_d;
    end
  end

  // Saturate rates into their ranges
  always_comb begin
    cfg_o.unlock    = unlock_q;
    cfg_o.cut_clamp = cut_clamp_q;
    cfg_o.dyn_pace  = dyn_pace_q;
    cfg_o.snap      = snap_q;
    priority if (min_rate_q < MIN_RATE_LO) cfg_o.min_rate = MIN_RATE_LO;
    else if (min_rate_q > MIN_RATE_HI)     cfg_o.min_rate = MIN_RATE_HI;
    else                                   cfg_o.min_rate = min_rate_q;
    priority if (tgt_rate_q < TGT_RATE_LO) cfg_o.tgt_rate = TGT_RATE_LO;
    else if (tgt_rate_q > TGT_RATE_HI)     cfg_o.tgt_rate = TGT_RATE_HI;
    else                                   cfg_o.tgt_rate = tgt_rate_q;
  end

endmodule

// ===== sv/fdq_divider.sv =====
// Restoring divider, one quotient bit per cycle, saturating on overflow.
module fdq_divider import fdq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TICK_W-1:0] rem_q, rem_d;
  logic [QW-1:0]     low_q, low_d;
  logic [QW-1:0]     quot_q, quot_d;
  logic [TICK_W-1:0] dvs_q, dvs_d;

  logic [HI_W-1:0]   hi;
  logic              ovf;
  logic [TICK_W:0]   trial;
  logic              ge;

  // Quotient at or above 2^QW when the top dividend bits reach the divisor
  assign hi    = req_i.dividend[DW-1:QW];
  assign ovf   = {{(TICK_W-HI_W){1'b0}}, hi} >= req_i.divisor;
  assign trial = {rem_q, low_q[QW-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    quot_d = quot_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      // Load, or saturate at once
      if (ovf) begin
        quot_d = '1;
        done_d = 1'b1;
      end else begin
        rem_d  = {{(TICK_W-HI_W){1'b0}}, hi};
        low_d  = req_i.dividend[QW-1:0];
        dvs_d  = req_i.divisor;
        cnt_d  = '0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      // Shift in one dividend bit, subtract when it fits
      rem_d  = ge ? TICK_W'(trial - {1'b0, dvs_q}) : trial[TICK_W-1:0];
      low_d  = {low_q[QW-2:0], 1'b0};
      quot_d = {quot_q[QW-2:0], ge};
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(QW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    low_q  <= low_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule
